// File: sv/svc_pkg.sv
// Package: shared types and codes for the silhouette voxel carver.
package svc_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_PIXEL  = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_HOLLOW = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    // View codes
    localparam logic [2:0] FACE_FRONT  = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_LEFT   = 3'd2;
    localparam logic [2:0] FACE_BACK   = 3'd3;
    localparam logic [2:0] FACE_BOTTOM = 3'd4;
    localparam logic [2:0] FACE_TOP    = 3'd5;

    localparam logic [7:0] ALPHA_SOLID = 8'd255;

    typedef struct packed {
        logic [1:0] func;
        logic       pass_index;
        logic [2:0] face;
        logic [4:0] col;
        logic [4:0] row;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [4:0] vox_x;
        logic [4:0] vox_y;
        logic [4:0] vox_z;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_item;

endpackage

// File: sv/svc_chan_if.sv
// Interface: valid/ready channel carrying one payload beat.
interface svc_chan_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: sv/svc_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module svc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/silhouette_voxel_carver_core.sv
// Top level: silhouette voxel carver with a sequenced single-port-style volume store.
// Carves an EDGE^3 RGBA volume (x innermost) from six silhouette views. The volume is
// kept as a 24-bit color RAM plus a 1-bit solid RAM, addressed {z,y,x} with each
// coordinate padded to ceil(log2(EDGE)) bits, so DEPTH = 2^(3*ceil(log2 EDGE)).
// One item is in work at a time and the input is not ready meanwhile. A pixel item
// walks its ray with a read state and a decide/write state per voxel. A read item
// passes a read state, then waits until the output is free to load its result beat.
// A clear item sweeps all DEPTH addresses. A hollow item copies the solid bits to a
// snapshot RAM (the last write overlapping the scan), then spends six snapshot reads
// and a decide on each interior voxel. After reset the block runs the same clearing
// pass before it takes its first item.
module silhouette_voxel_carver_core #(
    parameter int EDGE = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    svc_chan_if.sink                            i_in,
    svc_chan_if.source                          o_out
);
    localparam int CW    = $clog2(EDGE);
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CW-1:0] M     = CW'(EDGE - 1);
    localparam logic [CW-1:0] INNER = CW'(EDGE - 2);
    localparam logic [6:0]    EDGE7 = 7'(EDGE);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_RAY_RD, S_RAY_WR, S_SNAP, S_HNB, S_HFIN, S_RD, S_RDW
    } t_state;

    t_state            r_state;
    svc_pkg::t_in_item r_item;
    svc_pkg::t_out_item r_out;
    logic              r_out_valid;
    logic [AW-1:0]     r_cnt;
    logic [CW-1:0]     r_k;
    logic              r_found;
    logic              r_snap_wv;
    logic [AW-1:0]     r_snap_wa;
    logic [CW-1:0]     r_hx, r_hy, r_hz;
    logic [2:0]        r_n;
    logic              r_all;

    function automatic logic [AW-1:0] vaddr(logic [CW-1:0] x, logic [CW-1:0] y,
                                            logic [CW-1:0] z);
        return {z, y, x};
    endfunction

    // Ray voxel address for the current step
    logic [CW-1:0] c_c, c_r, rx, ry, rz;
    logic [AW-1:0] ray_addr;
    always_comb begin
        c_c = CW'(r_item.col);
        c_r = CW'(r_item.row);
        case (r_item.face)
            svc_pkg::FACE_FRONT:  begin rx = r_k;       ry = M - c_r; rz = c_c;       end
            svc_pkg::FACE_RIGHT:  begin rx = c_c;       ry = M - c_r; rz = M - r_k;   end
            svc_pkg::FACE_LEFT:   begin rx = M - c_c;   ry = M - c_r; rz = r_k;       end
            svc_pkg::FACE_BACK:   begin rx = M - r_k;   ry = M - c_r; rz = M - c_c;   end
            svc_pkg::FACE_BOTTOM: begin rx = c_r;       ry = r_k;     rz = c_c;       end
            default:              begin rx = M - c_r;   ry = M - r_k; rz = c_c;       end
        endcase
        ray_addr = vaddr(rx, ry, rz);
    end

    // Neighbor address for the hollow scan
    logic [AW-1:0] nb_addr;
    always_comb begin
        case (r_n)
            3'd0:    nb_addr = vaddr(r_hx + 1'b1, r_hy, r_hz);
            3'd1:    nb_addr = vaddr(r_hx - 1'b1, r_hy, r_hz);
            3'd2:    nb_addr = vaddr(r_hx, r_hy + 1'b1, r_hz);
            3'd3:    nb_addr = vaddr(r_hx, r_hy - 1'b1, r_hz);
            3'd4:    nb_addr = vaddr(r_hx, r_hy, r_hz + 1'b1);
            default: nb_addr = vaddr(r_hx, r_hy, r_hz - 1'b1);
        endcase
    end

    logic [AW-1:0] rd_addr;
    assign rd_addr = vaddr(CW'(r_item.vox_x), CW'(r_item.vox_y), CW'(r_item.vox_z));

    // Memories
    logic          rgb_we, sol_we, sol_wdata, sol_rdata, snap_rdata;
    logic [23:0]   rgb_wdata, rgb_rdata;
    logic [AW-1:0] waddr, raddr;

    svc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_rgb (
        .i_clk(i_clk), .i_we(rgb_we), .i_waddr(waddr), .i_wdata(rgb_wdata),
        .i_raddr(raddr), .o_rdata(rgb_rdata)
    );
    svc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_solid (
        .i_clk(i_clk), .i_we(sol_we), .i_waddr(waddr), .i_wdata(sol_wdata),
        .i_raddr(raddr), .o_rdata(sol_rdata)
    );
    svc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_snap (
        .i_clk(i_clk), .i_we(r_snap_wv), .i_waddr(r_snap_wa), .i_wdata(sol_rdata),
        .i_raddr(nb_addr), .o_rdata(snap_rdata)
    );

    // Ray decision terms
    logic px_front, px_opaque, px_clear;
    assign px_front  = (r_item.face == svc_pkg::FACE_FRONT);
    assign px_opaque = (r_item.alpha == svc_pkg::ALPHA_SOLID);
    assign px_clear  = (r_item.alpha == 8'd0);

    logic out_free, hollow_hit;
    assign out_free   = !r_out_valid || o_out.ready;
    assign hollow_hit = r_all && snap_rdata;

    // Memory port control
    always_comb begin
        rgb_we    = 1'b0;
        sol_we    = 1'b0;
        rgb_wdata = {r_item.blue, r_item.green, r_item.red};
        sol_wdata = 1'b1;
        waddr     = ray_addr;
        raddr     = ray_addr;
        case (r_state)
            S_CLR: begin
                rgb_we    = 1'b1;
                sol_we    = 1'b1;
                rgb_wdata = '0;
                sol_wdata = 1'b0;
                waddr     = r_cnt;
            end
            S_RAY_WR: begin
                if (px_front && !r_item.pass_index) begin
                    rgb_we    = 1'b1;
                    sol_we    = 1'b1;
                    sol_wdata = px_opaque;
                end else if (!px_front && !px_opaque) begin
                    sol_we    = !r_item.pass_index;
                    sol_wdata = 1'b0;
                end else if (px_front && px_clear) begin
                    sol_we = 1'b0;
                end else if (!r_found && sol_rdata) begin
                    rgb_we = 1'b1;
                    sol_we = 1'b1;
                end
            end
            S_SNAP: raddr = r_cnt;
            S_HFIN: begin
                waddr     = vaddr(r_hx, r_hy, r_hz);
                sol_we    = hollow_hit;
                sol_wdata = 1'b0;
            end
            S_RD, S_RDW: raddr = rd_addr;
            default: ;
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_snap_wv   <= 1'b0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_n         <= '0;
            r_all       <= 1'b1;
        end else begin
            r_snap_wv <= (r_state == S_SNAP);
            r_snap_wa <= r_cnt;
            // result beat taken; a new one loaded in S_RDW takes precedence
            if (r_out_valid && o_out.ready && r_state != S_RDW) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(DEPTH - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_item  <= i_in.data;
                        r_cnt   <= '0;
                        r_k     <= '0;
                        r_found <= 1'b0;
                        case (i_in.data.func)
                            svc_pkg::FUNC_PIXEL: begin
                                if (i_in.data.face <= svc_pkg::FACE_TOP &&
                                    {2'b00, i_in.data.col} < EDGE7 &&
                                    {2'b00, i_in.data.row} < EDGE7) begin
                                    r_state <= S_RAY_RD;
                                end
                            end
                            svc_pkg::FUNC_CLEAR:  r_state <= S_CLR;
                            svc_pkg::FUNC_HOLLOW: r_state <= S_SNAP;
                            default:              r_state <= S_RD;
                        endcase
                    end
                end
                S_RAY_RD: r_state <= S_RAY_WR;
                S_RAY_WR: begin
                    if (!(px_front && !r_item.pass_index) && (px_front || px_opaque) &&
                        !(px_front && px_clear) && sol_rdata) begin
                        r_found <= 1'b1;
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= (r_k == M) ? S_IDLE : S_RAY_RD;
                end
                S_SNAP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(DEPTH - 1)) begin
                        r_state <= S_HNB;
                        r_hx    <= CW'(1);
                        r_hy    <= CW'(1);
                        r_hz    <= CW'(1);
                        r_n     <= '0;
                        r_all   <= 1'b1;
                    end
                end
                S_HNB: begin
                    if (r_n != 3'd0) r_all <= r_all & snap_rdata;
                    r_n <= r_n + 1'b1;
                    if (r_n == 3'd5) r_state <= S_HFIN;
                end
                S_HFIN: begin
                    r_n   <= '0;
                    r_all <= 1'b1;
                    r_state <= S_HNB;
                    if (r_hx == INNER) begin
                        r_hx <= CW'(1);
                        if (r_hy == INNER) begin
                            r_hy <= CW'(1);
                            if (r_hz == INNER) r_state <= S_IDLE;
                            else r_hz <= r_hz + 1'b1;
                        end else begin
                            r_hy <= r_hy + 1'b1;
                        end
                    end else begin
                        r_hx <= r_hx + 1'b1;
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if ({2'b00, r_item.vox_x} < EDGE7 && {2'b00, r_item.vox_y} < EDGE7 &&
                            {2'b00, r_item.vox_z} < EDGE7) begin
                            r_out.out_red   <= rgb_rdata[7:0];
                            r_out.out_green <= rgb_rdata[15:8];
                            r_out.out_blue  <= rgb_rdata[23:16];
                            r_out.out_alpha <= sol_rdata ? svc_pkg::ALPHA_SOLID : 8'd0;
                        end else begin
                            r_out <= '0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: dv/silhouette_voxel_carver_core_tb.sv
// Testbench: directed table plus random carving scenes, checked against a voxel volume predictor.
module silhouette_voxel_carver_core_tb;

    localparam int EDGE      = 32;
    localparam int M         = EDGE - 1;
    localparam int VOXELS    = EDGE * EDGE * EDGE;
    localparam int MAX_CYC   = 3_000_000;
    localparam int HOLD_CYC  = 300;
    localparam int DRAIN_CYC = 200;

    logic i_clk;
    logic i_rst_n;

    svc_chan_if #(.t_payload(svc_pkg::t_in_item))  in_ch();
    svc_chan_if #(.t_payload(svc_pkg::t_out_item)) out_ch();

    silhouette_voxel_carver_core #(.EDGE(EDGE)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Directed stimulus table
    typedef struct {
        svc_pkg::t_in_item  item;
        bit                 typed;
        svc_pkg::t_out_item want;
    } t_row;

    // Predicted volume, {z,y,x} addressed, word = {alpha, blue, green, red}
    logic [31:0]        vol_pred [0:VOXELS-1];
    logic [7:0]         alpha_snap [0:VOXELS-1];
    svc_pkg::t_out_item voxels_due[$];
    t_row               dir_rows[$];
    int                 n_errors;
    int                 n_cycles;
    int                 hold_req;

    function automatic int vaddr(int x, int y, int z);
        return (z * EDGE + y) * EDGE + x;
    endfunction

    // Append one expected read beat
    function automatic void queue_voxel(svc_pkg::t_out_item v);
        voxels_due.insert(voxels_due.size(), v);
    endfunction

    // Append one row to the directed table
    function automatic void add_row(svc_pkg::t_in_item it, bit typed, svc_pkg::t_out_item want);
        t_row rw;
        rw.item  = it;
        rw.typed = typed;
        rw.want  = want;
        dir_rows.insert(dir_rows.size(), rw);
    endfunction

    // Walk one ray and paint, carve or recolor along it
    function automatic void carve_ray(svc_pkg::t_in_item it);
        int          x, y, z, a, c, r;
        bit          found;
        logic [23:0] rgb;
        found = 0;
        c     = int'(it.col);
        r     = int'(it.row);
        rgb   = {it.blue, it.green, it.red};
        if (it.face > svc_pkg::FACE_TOP) return;
        for (int k = 0; k < EDGE; k++) begin
            case (it.face)
                svc_pkg::FACE_FRONT:  begin x = k;     y = M - r; z = c;     end
                svc_pkg::FACE_RIGHT:  begin x = c;     y = M - r; z = M - k; end
                svc_pkg::FACE_LEFT:   begin x = M - c; y = M - r; z = k;     end
                svc_pkg::FACE_BACK:   begin x = M - k; y = M - r; z = M - c; end
                svc_pkg::FACE_BOTTOM: begin x = r;     y = k;     z = c;     end
                default:              begin x = M - r; y = M - k; z = c;     end
            endcase
            a = vaddr(x, y, z);
            if (it.face == svc_pkg::FACE_FRONT && it.pass_index == 1'b0) begin
                vol_pred[a] = {(it.alpha == svc_pkg::ALPHA_SOLID) ? 8'hFF : 8'h00, rgb};
            end else if (it.face != svc_pkg::FACE_FRONT && it.alpha != svc_pkg::ALPHA_SOLID) begin
                if (it.pass_index == 1'b0) vol_pred[a][31:24] = 8'h00;
            end else if (it.face == svc_pkg::FACE_FRONT && it.alpha == 8'h00) begin
                // transparent pixel in the second front pass: no change
            end else if (!found && vol_pred[a][31:24] == svc_pkg::ALPHA_SOLID) begin
                found       = 1;
                vol_pred[a] = {svc_pkg::ALPHA_SOLID, rgb};
            end
        end
    endfunction

    // Hollow against a snapshot of the alphas taken before the sweep
    function automatic void hollow_volume();
        for (int i = 0; i < VOXELS; i++) alpha_snap[i] = vol_pred[i][31:24];
        for (int z = 1; z < M; z++)
            for (int y = 1; y < M; y++)
                for (int x = 1; x < M; x++)
                    if (alpha_snap[vaddr(x+1, y, z)] != 0 && alpha_snap[vaddr(x-1, y, z)] != 0 &&
                        alpha_snap[vaddr(x, y+1, z)] != 0 && alpha_snap[vaddr(x, y-1, z)] != 0 &&
                        alpha_snap[vaddr(x, y, z+1)] != 0 && alpha_snap[vaddr(x, y, z-1)] != 0)
                        vol_pred[vaddr(x, y, z)][31:24] = 8'h00;
    endfunction

    // Advance the predicted volume by one accepted beat, queue a read result
    function automatic void predict_voxel(svc_pkg::t_in_item it);
        logic [31:0] w;
        case (it.func)
            svc_pkg::FUNC_PIXEL:  carve_ray(it);
            svc_pkg::FUNC_CLEAR:  for (int i = 0; i < VOXELS; i++) vol_pred[i] = '0;
            svc_pkg::FUNC_HOLLOW: hollow_volume();
            default: begin
                w = vol_pred[vaddr(int'(it.vox_x), int'(it.vox_y), int'(it.vox_z))];
                queue_voxel('{out_red: w[7:0], out_green: w[15:8],
                              out_blue: w[23:16], out_alpha: w[31:24]});
            end
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", n_cycles, msg);
        n_errors++;
    endtask

    // Offer one beat after a random gap; valid stays high when the gap is zero
    task automatic send_beat(svc_pkg::t_in_item it);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_voxel(it);
    endtask

    // Drop valid after the last accepted beat before a pause
    task automatic idle_input();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic svc_pkg::t_in_item pixel(bit p, logic [2:0] f, int c, int r,
                                                logic [7:0] rd, logic [7:0] g,
                                                logic [7:0] b, logic [7:0] a);
        svc_pkg::t_in_item it;
        it = svc_pkg::t_in_item'($urandom());
        it.func = svc_pkg::FUNC_PIXEL; it.pass_index = p; it.face = f;
        it.col = 5'(c); it.row = 5'(r); it.red = rd; it.green = g; it.blue = b; it.alpha = a;
        return it;
    endfunction

    function automatic svc_pkg::t_in_item read_at(int x, int y, int z);
        svc_pkg::t_in_item it;
        it = '0;
        it.func = svc_pkg::FUNC_READ; it.vox_x = 5'(x); it.vox_y = 5'(y); it.vox_z = 5'(z);
        return it;
    endfunction

    function automatic svc_pkg::t_in_item op_only(logic [1:0] f);
        svc_pkg::t_in_item it;
        it = svc_pkg::t_in_item'({$urandom(), $urandom(), $urandom()});
        it.func = f;
        return it;
    endfunction

    // Random item, mostly aimed at a small window of columns and rows
    function automatic svc_pkg::t_in_item scene_item(int c0, int r0, int sz);
        svc_pkg::t_in_item it;
        int                sel;
        sel = $urandom_range(0, 99);
        it  = svc_pkg::t_in_item'({$urandom(), $urandom(), $urandom()});
        if (sel < 30) begin
            it = read_at($urandom_range(0, M), M - (r0 + $urandom_range(0, sz - 1)),
                         c0 + $urandom_range(0, sz - 1));
        end else if (sel < 35) begin
            it.func = svc_pkg::FUNC_READ;
        end else if (sel < 92) begin
            it.func = svc_pkg::FUNC_PIXEL;
            it.face = 3'($urandom_range(0, 5));
            it.col  = 5'(c0 + $urandom_range(0, sz - 1));
            it.row  = 5'(r0 + $urandom_range(0, sz - 1));
            if ($urandom_range(0, 1)) it.alpha = svc_pkg::ALPHA_SOLID;
        end else begin
            it.func = svc_pkg::FUNC_PIXEL;
            if ($urandom_range(0, 1)) it.face = 3'($urandom_range(6, 7));
        end
        return it;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > MAX_CYC) begin
            $display("Timeout after %0d cycles", n_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        int                 stall;
        int                 hold_seen;
        svc_pkg::t_out_item got, want;
        hold_seen    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen    = hold_req;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
            end
            stall = $urandom_range(0, 3);
            if (stall > 0) begin
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            got = out_ch.data;
            if (voxels_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                want = voxels_due.pop_front();
                if (got.out_red !== want.out_red)
                    report_mismatch($sformatf("red %h want %h", got.out_red, want.out_red));
                if (got.out_green !== want.out_green)
                    report_mismatch($sformatf("green %h want %h", got.out_green, want.out_green));
                if (got.out_blue !== want.out_blue)
                    report_mismatch($sformatf("blue %h want %h", got.out_blue, want.out_blue));
                if (got.out_alpha !== want.out_alpha)
                    report_mismatch($sformatf("alpha %h want %h", got.out_alpha, want.out_alpha));
            end
        end
    end

    // Stimulus
    initial begin
        int c0, r0, sz, n_mix;
        for (int i = 0; i < VOXELS; i++) vol_pred[i] = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset contents, extremes, every face and pass, ignored faces
        add_row(read_at(0, 0, 0), 1, '0);
        add_row(read_at(M, M, M), 1, '0);
        add_row(pixel(0, svc_pkg::FACE_FRONT, 0, 0, 8'h01, 8'h02, 8'h03,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(read_at(5, M, 0), 1, '{8'h01, 8'h02, 8'h03, svc_pkg::ALPHA_SOLID});
        add_row(pixel(0, svc_pkg::FACE_FRONT, M, M, 8'hFF, 8'hFF, 8'hFF, 8'h00), 0, '0);
        add_row(read_at(M, 0, M), 1, '{8'hFF, 8'hFF, 8'hFF, 8'h00});
        add_row(pixel(1, svc_pkg::FACE_FRONT, 0, 0, 8'h10, 8'h20, 8'h30, 8'h80), 0, '0);
        add_row(read_at(0, M, 0), 0, '0);
        add_row(pixel(1, svc_pkg::FACE_FRONT, 0, 0, 8'hAA, 8'hBB, 8'hCC, 8'h00), 0, '0);
        add_row(pixel(0, svc_pkg::FACE_RIGHT, 0, 0, 8'h55, 8'h66, 8'h77, 8'hFE), 0, '0);
        add_row(read_at(0, M, 0), 0, '0);
        add_row(pixel(0, svc_pkg::FACE_FRONT, 3, 0, 8'h21, 8'h22, 8'h23,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(pixel(1, svc_pkg::FACE_LEFT, M - 1, 0, 8'h31, 8'h32, 8'h33,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(pixel(0, svc_pkg::FACE_BACK, 3, 0, 8'h41, 8'h42, 8'h43,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(pixel(1, svc_pkg::FACE_BOTTOM, 3, 5, 8'h51, 8'h52, 8'h53,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(pixel(0, svc_pkg::FACE_TOP, 3, M - 5, 8'h61, 8'h62, 8'h63,
                      svc_pkg::ALPHA_SOLID), 0, '0);
        add_row(pixel(1, svc_pkg::FACE_BOTTOM, 3, 6, 8'h71, 8'h72, 8'h73, 8'h05), 0, '0);
        add_row(pixel(0, 3'd6, 3, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(pixel(0, 3'd7, 3, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, '0);
        add_row(read_at(0, M, 3), 0, '0);
        add_row(read_at(M, M, 3), 0, '0);
        add_row(read_at(5, M, 3), 0, '0);
        add_row(op_only(svc_pkg::FUNC_CLEAR), 0, '0);
        add_row(read_at(5, M, 3), 1, '0);
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].item);
            // typed rows override the predicted value with the one read off by hand
            if (dir_rows[i].typed) voxels_due[voxels_due.size() - 1] = dir_rows[i].want;
        end

        // Random scenes: fill a window from the front, then carve, recolor and read it
        for (int s = 0; s < 20; s++) begin
            sz = $urandom_range(3, 6);
            if (s == 3) begin
                sz = 8;
            end
            c0 = $urandom_range(0, EDGE - sz);
            r0 = $urandom_range(0, EDGE - sz);
            for (int c = c0; c < c0 + sz; c++)
                for (int r = r0; r < r0 + sz; r++)
                    send_beat(pixel(0, svc_pkg::FACE_FRONT, c, r, 8'($urandom()),
                                    8'($urandom()), 8'($urandom()),
                                    ($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                                : svc_pkg::ALPHA_SOLID));
            if (s == 3) begin
                // one full hollow on a solid block, then probe its inside and skin
                send_beat(op_only(svc_pkg::FUNC_HOLLOW));
                repeat (12) send_beat(read_at($urandom_range(0, M),
                                              M - (r0 + $urandom_range(0, sz - 1)),
                                              c0 + $urandom_range(0, sz - 1)));
            end
            if (s == 2) begin
                hold_req++;
                repeat (6) send_beat(read_at($urandom_range(0, M), M - r0, c0));
            end
            n_mix = (s == 3) ? 10 : 30;
            repeat (n_mix) send_beat(scene_item(c0, r0, sz));
            if (s % 4 == 1) begin
                idle_input();
                wait (voxels_due.size() == 0);
            end
            if (s == 7 || s == 14) send_beat(op_only(svc_pkg::FUNC_CLEAR));
        end
        idle_input();

        wait (voxels_due.size() == 0);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: silhouette_voxel_carver_core.f
sv/svc_pkg.sv
sv/svc_chan_if.sv
sv/svc_ram.sv
sv/silhouette_voxel_carver_core.sv
dv/silhouette_voxel_carver_core_tb.sv
